// File: hw/rtl/servo_pwm_pkg.sv
// Shared types and constants for the multi-channel servo PWM block.
`timescale 1ns / 1ps

package servo_pwm_pkg;

  localparam int CHANNELS   = 6;
  localparam int CH_BITS    = 3;
  localparam int ANGLE_BITS = 8;

  typedef enum logic {
    REQ_TICK = 1'b0,
    REQ_SET  = 1'b1
  } req_e;

  typedef struct packed {
    req_e                  req_type;
    logic [CH_BITS-1:0]    channel;
    logic                  channel_active;
    logic [ANGLE_BITS-1:0] angle;
  } in_t;

  typedef struct packed {
    logic [CHANNELS-1:0] pin_levels;
    logic                period_start;
  } out_t;

endpackage

// File: hw/rtl/servo_pwm_scale.sv
// Angle to duty conversion through a constant lookup table.
`timescale 1ns / 1ps

module servo_pwm_scale #(
  parameter int AngleMax = 180,
  parameter int DutyMax  = 26,
  localparam int DutyW   = $clog2(DutyMax + 1)
) (
  input  logic                                   active_i,
  input  logic [servo_pwm_pkg::ANGLE_BITS-1:0]   angle_i,
  output logic [DutyW-1:0]                       duty_o
);

  localparam int LutDepth = 2 ** servo_pwm_pkg::ANGLE_BITS;

  typedef logic [DutyW-1:0] lut_t [LutDepth];

  function automatic lut_t build_lut();
    lut_t lut;
    int   a;
    for (int i = 0; i < LutDepth; i++) begin
      a      = (i > AngleMax) ? AngleMax : i;
      lut[i] = DutyW'((a * DutyMax) / AngleMax);
    end
    return lut;
  endfunction

  localparam lut_t DutyLut = build_lut();

  assign duty_o = active_i ? DutyLut[angle_i] : '0;

endmodule

// File: hw/rtl/multi_channel_servo_pwm.sv
// Top level of the multi-channel servo PWM generator.
`timescale 1ns / 1ps

// Six-channel servo PWM generator. A set-duty beat stores a pending duty of
// min(angle, ANGLE_MAX) * DUTY_MAX / ANGLE_MAX for one channel (zero when the
// channel is inactive; channels beyond the last are ignored) and returns no
// beat. A tick beat returns the pin levels held before it, then advances the
// wrapping period counter; on the wrap to zero the pending duties go active,
// all pins rise and period_start is set. A pin drops when its active duty
// equals the counter. Each beat passes an input register and one level of
// logic into the output register: one beat per cycle, while a tick is not
// held by an output beat that waits for out_ready.
module multi_channel_servo_pwm #(
  parameter int COUNT_BITS = 8,
  parameter int ANGLE_MAX  = 180,
  parameter int DUTY_MAX   = 26
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  servo_pwm_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output servo_pwm_pkg::out_t out_data_o
);

  localparam int NumCh  = servo_pwm_pkg::CHANNELS;
  localparam int DutyW  = $clog2(DUTY_MAX + 1);
  localparam int CmpW   = (COUNT_BITS > DutyW) ? COUNT_BITS : DutyW;

  logic                  in_vld_q;
  servo_pwm_pkg::in_t    in_q;
  logic                  out_vld_q;
  servo_pwm_pkg::out_t   out_q;

  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [NumCh-1:0]      pin_q, pin_d;
  logic [DutyW-1:0]      act_q [NumCh];
  logic [DutyW-1:0]      act_d [NumCh];
  logic [DutyW-1:0]      pend_q [NumCh];
  logic [DutyW-1:0]      new_duty;

  logic                  is_set;
  logic                  fire;
  logic                  tick;
  logic                  set_en;
  logic                  wrap;

  assign is_set = (in_q.req_type == servo_pwm_pkg::REQ_SET);
  assign fire   = in_vld_q && (is_set || !out_vld_q || out_ready_i);
  assign tick   = fire && !is_set;
  assign set_en = fire && is_set
                  && ({1'b0, in_q.channel} < (servo_pwm_pkg::CH_BITS + 1)'(NumCh));

  assign in_ready_o = !in_vld_q || fire;

  servo_pwm_scale #(
    .AngleMax (ANGLE_MAX),
    .DutyMax  (DUTY_MAX)
  ) u_scale (
    .active_i (in_q.channel_active),
    .angle_i  (in_q.angle),
    .duty_o   (new_duty)
  );

  // advance counter, load duties on wrap, drop matching pins
  always_comb begin
    cnt_d = cnt_q + COUNT_BITS'(1);
    wrap  = (cnt_d == '0);
    pin_d = wrap ? '1 : pin_q;
    for (int i = 0; i < NumCh; i++) begin
      act_d[i] = wrap ? pend_q[i] : act_q[i];
      if (CmpW'(act_d[i]) == CmpW'(cnt_d)) begin
        pin_d[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      cnt_q     <= '1;
      pin_q     <= '1;
      for (int i = 0; i < NumCh; i++) begin
        act_q[i]  <= '0;
        pend_q[i] <= '0;
      end
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (tick) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      if (tick) begin
        cnt_q <= cnt_d;
        pin_q <= pin_d;
        for (int i = 0; i < NumCh; i++) begin
          act_q[i] <= act_d[i];
        end
      end
      if (set_en) begin
        pend_q[in_q.channel] <= new_duty;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (tick) begin
      out_q.pin_levels   <= pin_q;
      out_q.period_start <= wrap;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// File: verif/tb_multi_channel_servo_pwm.sv
// Testbench for the multi-channel servo PWM block: predicts each tick result and checks it.
`timescale 1ns / 1ps

module tb_multi_channel_servo_pwm;

  localparam int COUNT_BITS    = 8;
  localparam int ANGLE_MAX     = 180;
  localparam int DUTY_MAX      = 26;
  localparam int RANDOM_BEATS  = 740;
  localparam int WATCHDOG_MAX  = 2000;
  localparam int DRAIN_CYCLES  = 8;

  class pwm_scoreboard;
    logic [COUNT_BITS-1:0]              period_count;
    logic [4:0]                         active_duty [servo_pwm_pkg::CHANNELS];
    logic [4:0]                         pending_duty [servo_pwm_pkg::CHANNELS];
    logic [servo_pwm_pkg::CHANNELS-1:0] pin_state;
    servo_pwm_pkg::out_t                levels_q [$];
    int                                 errors;
    int                                 n_checked;
    int                                 n_ticks;
    int                                 n_sets;
    int                                 n_ignored;
    int                                 n_wraps;

    function new();
      period_count = '1;
      pin_state    = '1;
      foreach (active_duty[i]) begin
        active_duty[i]  = '0;
        pending_duty[i] = '0;
      end
    endfunction

    function logic [4:0] scale_angle(logic act, logic [7:0] ang);
      int deg;
      deg = act ? int'(ang) : 0;
      if (deg > ANGLE_MAX) deg = ANGLE_MAX;
      return 5'((deg * DUTY_MAX) / ANGLE_MAX);
    endfunction

    function void note_beat(servo_pwm_pkg::in_t b);
      servo_pwm_pkg::out_t want;
      if (b.req_type == servo_pwm_pkg::REQ_SET) begin
        n_sets++;
        if (b.channel < servo_pwm_pkg::CHANNELS)
          pending_duty[b.channel] = scale_angle(b.channel_active, b.angle);
        else n_ignored++;
        return;
      end
      n_ticks++;
      want.pin_levels   = pin_state;
      period_count      = period_count + COUNT_BITS'(1);
      want.period_start = (period_count == '0);
      if (want.period_start) begin
        n_wraps++;
        foreach (active_duty[i]) active_duty[i] = pending_duty[i];
        pin_state = '1;
      end
      foreach (active_duty[i]) begin
        if (COUNT_BITS'(active_duty[i]) == period_count) pin_state[i] = 1'b0;
      end
      levels_q.push_back(want);
    endfunction

    task report_mismatch(string what, logic [31:0] got_v, logic [31:0] want_v);
      errors++;
      $display("%0t MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got_v, want_v);
    endtask

    task check_beat(servo_pwm_pkg::out_t got);
      servo_pwm_pkg::out_t want;
      n_checked++;
      if (levels_q.size() == 0) begin
        report_mismatch("result beat with nothing pending", 32'(got), '0);
        return;
      end
      want = levels_q.pop_front();
      if (got.pin_levels !== want.pin_levels)
        report_mismatch("pin_levels", 32'(got.pin_levels), 32'(want.pin_levels));
      if (got.period_start !== want.period_start)
        report_mismatch("period_start", 32'(got.period_start), 32'(want.period_start));
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  servo_pwm_pkg::in_t  in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  servo_pwm_pkg::out_t out_data_o;
  pwm_scoreboard       sb;
  int                  idle_cycles = 0;

  multi_channel_servo_pwm #(
    .COUNT_BITS(COUNT_BITS),
    .ANGLE_MAX (ANGLE_MAX),
    .DUTY_MAX  (DUTY_MAX)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 8) return $urandom_range(15, 40);
    if (r < 50) return $urandom_range(1, 3);
    return 0;
  endfunction

  function servo_pwm_pkg::in_t set_beat(int ch, bit act, int ang);
    servo_pwm_pkg::in_t b;
    b.req_type       = servo_pwm_pkg::REQ_SET;
    b.channel        = ch[2:0];
    b.channel_active = act;
    b.angle          = ang[7:0];
    return b;
  endfunction

  function servo_pwm_pkg::in_t tick_beat();
    servo_pwm_pkg::in_t b;
    b.req_type       = servo_pwm_pkg::REQ_TICK;
    b.channel        = 3'($urandom_range(0, 7));
    b.channel_active = 1'($urandom_range(0, 1));
    b.angle          = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function servo_pwm_pkg::in_t random_beat();
    int ch;
    int ang;
    if ($urandom_range(0, 99) < 85) return tick_beat();
    ch = ($urandom_range(0, 9) < 8) ? $urandom_range(0, servo_pwm_pkg::CHANNELS - 1)
                                    : $urandom_range(6, 7);
    case ($urandom_range(0, 3))
      0, 3: ang = $urandom_range(0, ANGLE_MAX);
      1: ang = $urandom_range(0, 255);
      default: begin
        case ($urandom_range(0, 3))
          0: ang = 0;
          1: ang = ANGLE_MAX;
          2: ang = ANGLE_MAX + 1;
          default: ang = 255;
        endcase
      end
    endcase
    return set_beat(ch, ($urandom_range(0, 9) != 0), ang);
  endfunction

  task send_beat(servo_pwm_pkg::in_t b, int gap);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i  = b;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task wait_drained();
    while (sb.levels_q.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_beat(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_beat(out_data_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_MAX) begin
      $display("Watchdog expired after %0d cycles without a beat", idle_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    bit quiet;
    int stall_left;
    out_ready_i = 1'b0;
    stall_left  = 0;
    @(posedge rst_ni);
    forever begin
      quiet = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(20, 80)) begin
        @(negedge clk_i);
        if (stall_left > 0) begin
          out_ready_i = 1'b0;
          stall_left--;
        end else begin
          out_ready_i = 1'b1;
          stall_left  = pick_gap(quiet);
        end
      end
    end
  end

  initial begin
    bit quiet;
    sb          = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_beat(set_beat(0, 1'b1, 0), 0);
    send_beat(set_beat(1, 1'b1, ANGLE_MAX), 0);
    send_beat(set_beat(2, 1'b1, ANGLE_MAX + 1), 0);
    send_beat(set_beat(3, 1'b1, 255), 0);
    send_beat(set_beat(4, 1'b0, 255), 0);
    send_beat(set_beat(5, 1'b1, 7), 0);
    send_beat(set_beat(6, 1'b1, 90), 0);
    send_beat(set_beat(7, 1'b0, 0), 0);
    repeat (4) send_beat(tick_beat(), 0);
    send_beat(set_beat(5, 1'b1, 179), 0);
    send_beat(set_beat(0, 1'b0, 0), 0);
    send_beat(set_beat(7, 1'b1, 255), 0);
    repeat (6) send_beat(tick_beat(), 1);

    quiet = 1'b0;
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (i == RANDOM_BEATS / 2) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        wait_drained();
      end
      send_beat(random_beat(), pick_gap(quiet));
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d ticks over %0d period starts and %0d duty writes (%0d to absent channels)",
             sb.n_ticks, sb.n_wraps, sb.n_sets, sb.n_ignored);
    $display("Checked %0d result beats, %0d mismatches", sb.n_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/servo_pwm_pkg.sv
hw/rtl/servo_pwm_scale.sv
hw/rtl/multi_channel_servo_pwm.sv
verif/tb_multi_channel_servo_pwm.sv
